FILE: hw/rtl/mdts_pkg.sv
// Shared types and constants for the multiplexed decimal tube scanner.
// Depends on nothing; every other file refers to it by scoped names.
`timescale 1ns / 1ps

package mdts_pkg;

  localparam int VALUE_W  = 20;
  localparam int ENABLE_W = 6;
  localparam int NOW_W    = 32;
  localparam int CODE_W   = 4;
  localparam int SELECT_W = 6;
  localparam int TUBE_W   = 3;
  localparam int ON_TIME_W = 16;

  localparam logic [ON_TIME_W-1:0] ON_TIME_RESET = 16'd2;

  // APB map: on_time at byte address 0
  localparam int PADDR_W = 3;
  localparam logic REG_ON_TIME = 1'b0;

  // values above the six-digit range wrap once
  localparam logic [VALUE_W-1:0] VALUE_MOD = 20'd1000000;

  // q = (v * RECIP_M[k]) >> RECIP_S[k] equals v / 10^k, exact for any 20-bit v
  localparam int RECIP_W = 21;
  localparam int PROD_W  = VALUE_W + RECIP_W;
  localparam int SHIFT_W = 6;
  localparam int POW_N   = 7;

  localparam logic [RECIP_W-1:0] RECIP_M [POW_N] = '{
    21'd1, 21'd1677722, 21'd1342178, 21'd1073742,
    21'd1717987, 21'd1374390, 21'd1099512
  };
  localparam logic [SHIFT_W-1:0] RECIP_S [POW_N] = '{
    6'd0, 6'd24, 6'd27, 6'd30, 6'd34, 6'd37, 6'd40
  };

  typedef struct packed {
    logic [VALUE_W-1:0]  value;   // already reduced below 1000000
    logic [TUBE_W-1:0]   tube;
    logic [SELECT_W-1:0] select;
    logic                lit;
  } scan_item_t;

  function automatic logic [CODE_W-1:0] code_of_digit(input logic [3:0] digit);
    logic [CODE_W-1:0] code;
    unique case (digit)
      4'd0: code = 4'd1;
      4'd1: code = 4'd0;
      4'd2: code = 4'd9;
      4'd3: code = 4'd8;
      4'd4: code = 4'd7;
      4'd5: code = 4'd6;
      4'd6: code = 4'd5;
      4'd7: code = 4'd4;
      4'd8: code = 4'd3;
      4'd9: code = 4'd2;
      default: code = 4'd0;
    endcase
    return code;
  endfunction

endpackage

FILE: hw/rtl/mdts_if.sv
// Valid/ready channel interfaces for scanner items and scanner results.
// Depends on mdts_pkg for field widths.
`timescale 1ns / 1ps

interface mdts_item_if;
  logic                          valid;
  logic                          ready;
  logic [mdts_pkg::VALUE_W-1:0]  display_value;
  logic [mdts_pkg::ENABLE_W-1:0] tube_enable;
  logic [mdts_pkg::NOW_W-1:0]    now_tick;

  modport source (output valid, display_value, tube_enable, now_tick, input ready);
  modport sink   (input valid, display_value, tube_enable, now_tick, output ready);
endinterface

interface mdts_result_if;
  logic                          valid;
  logic                          ready;
  logic [mdts_pkg::CODE_W-1:0]   digit_code;
  logic [mdts_pkg::SELECT_W-1:0] tube_select;
  logic                          lit;

  modport source (output valid, digit_code, tube_select, lit, input ready);
  modport sink   (input valid, digit_code, tube_select, lit, output ready);
endinterface

FILE: hw/rtl/mdts_front.sv
// Front end: scan phase / tube state machine updated on every accepted item.
// Depends on mdts_pkg; emits one scan_item_t per transfer into the queue.
`timescale 1ns / 1ps

module mdts_front #(
  parameter int NUM_TUBES  = 6,
  parameter int TICK_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              accept,
  input  logic [mdts_pkg::VALUE_W-1:0]      display_value,
  input  logic [mdts_pkg::ENABLE_W-1:0]     tube_enable,
  input  logic [mdts_pkg::NOW_W-1:0]        now_tick,
  input  logic [mdts_pkg::ON_TIME_W-1:0]    on_time,
  output mdts_pkg::scan_item_t              entry
);

  localparam int CMP_W = (TICK_WIDTH > mdts_pkg::ON_TIME_W) ? TICK_WIDTH
                                                            : mdts_pkg::ON_TIME_W;
  localparam logic [mdts_pkg::TUBE_W-1:0] TUBE_LAST = mdts_pkg::TUBE_W'(NUM_TUBES - 1);

  logic                          scan_phase, scan_phase_next;
  logic [mdts_pkg::TUBE_W-1:0]   current_tube, current_tube_next;
  logic [TICK_WIDTH-1:0]         phase_start_time, phase_start_time_next;
  logic [TICK_WIDTH-1:0]         now_t;
  logic [TICK_WIDTH-1:0]         elapsed;
  logic                          expired;

  assign now_t   = now_tick[TICK_WIDTH-1:0];
  assign elapsed = now_t - phase_start_time;
  assign expired = CMP_W'(elapsed) > CMP_W'(on_time);

  always_comb begin
    scan_phase_next       = scan_phase;
    current_tube_next     = current_tube;
    phase_start_time_next = phase_start_time;
    if (scan_phase) begin
      if (expired) begin
        current_tube_next     = (current_tube == TUBE_LAST) ? '0 : current_tube + 1'b1;
        scan_phase_next       = 1'b0;
        phase_start_time_next = now_t;
      end
    end else begin
      scan_phase_next       = 1'b1;
      phase_start_time_next = now_t;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_phase       <= 1'b0;
      current_tube     <= '0;
      phase_start_time <= '0;
    end else if (accept) begin
      scan_phase       <= scan_phase_next;
      current_tube     <= current_tube_next;
      phase_start_time <= phase_start_time_next;
    end
  end

  always_comb begin
    entry.value  = (display_value >= mdts_pkg::VALUE_MOD) ?
                   display_value - mdts_pkg::VALUE_MOD : display_value;
    entry.tube   = current_tube_next;
    entry.lit    = scan_phase_next;
    entry.select = '0;
    if (scan_phase_next && tube_enable[current_tube_next])
      entry.select[current_tube_next] = 1'b1;
  end

endmodule

FILE: hw/rtl/mdts_queue.sv
// Two-entry queue between the scan front end and the digit back end.
// Depends on mdts_pkg for the entry type.
`timescale 1ns / 1ps

module mdts_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  mdts_pkg::scan_item_t  push_data,
  output logic                  full,
  input  logic                  pop,
  output logic                  not_empty,
  output mdts_pkg::scan_item_t  head
);

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);

  mdts_pkg::scan_item_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [PTR_W:0]   count;

  assign full      = (count == (PTR_W + 1)'(DEPTH));
  assign not_empty = (count != '0);
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push)
      mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push)
        wr_ptr <= wr_ptr + 1'b1;
      if (pop)
        rd_ptr <= rd_ptr + 1'b1;
      count <= count + (PTR_W + 1)'(push) - (PTR_W + 1)'(pop);
    end
  end

endmodule

FILE: hw/rtl/mdts_back.sv
// Back end: decimal digit extraction by reciprocal multiply, code lookup,
// held cathode code and the result register. Depends on mdts_pkg.
`timescale 1ns / 1ps

module mdts_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          head_valid,
  input  mdts_pkg::scan_item_t          head,
  output logic                          pop,
  output logic                          res_valid,
  input  logic                          res_ready,
  output logic [mdts_pkg::CODE_W-1:0]   digit_code,
  output logic [mdts_pkg::SELECT_W-1:0] tube_select,
  output logic                          lit
);

  logic advance;

  // multiply stage
  logic                          s1_valid;
  logic [mdts_pkg::PROD_W-1:0]   s1_prod_lo, s1_prod_hi;
  logic [mdts_pkg::SHIFT_W-1:0]  s1_shift_lo, s1_shift_hi;
  logic [mdts_pkg::SELECT_W-1:0] s1_select;
  logic                          s1_lit;

  logic [mdts_pkg::TUBE_W-1:0]   idx_hi;
  logic [mdts_pkg::PROD_W-1:0]   q_lo_full, q_hi_full;
  logic [mdts_pkg::VALUE_W-1:0]  q_lo, q_hi, rem;
  logic [mdts_pkg::CODE_W-1:0]   new_code;

  assign advance = !res_valid || res_ready;
  assign pop     = advance && head_valid;
  assign idx_hi  = head.tube + 1'b1;

  always_ff @(posedge clk) begin
    if (rst)
      s1_valid <= 1'b0;
    else if (advance)
      s1_valid <= head_valid;
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_prod_lo  <= mdts_pkg::PROD_W'(head.value) *
                     mdts_pkg::PROD_W'(mdts_pkg::RECIP_M[head.tube]);
      s1_prod_hi  <= mdts_pkg::PROD_W'(head.value) *
                     mdts_pkg::PROD_W'(mdts_pkg::RECIP_M[idx_hi]);
      s1_shift_lo <= mdts_pkg::RECIP_S[head.tube];
      s1_shift_hi <= mdts_pkg::RECIP_S[idx_hi];
      s1_select   <= head.select;
      s1_lit      <= head.lit;
    end
  end

  // digit = floor(v / 10^t) - 10 * floor(v / 10^(t+1))
  assign q_lo_full = s1_prod_lo >> s1_shift_lo;
  assign q_hi_full = s1_prod_hi >> s1_shift_hi;
  assign q_lo      = q_lo_full[mdts_pkg::VALUE_W-1:0];
  assign q_hi      = q_hi_full[mdts_pkg::VALUE_W-1:0];
  assign rem       = q_lo - ((q_hi << 3) + (q_hi << 1));
  assign new_code  = mdts_pkg::code_of_digit(rem[3:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      digit_code <= '0;
    end else if (advance) begin
      res_valid <= s1_valid;
      if (s1_valid && s1_lit)
        digit_code <= new_code;   // blanking keeps the held code
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      tube_select <= s1_select;
      lit         <= s1_lit;
    end
  end

endmodule

FILE: hw/rtl/multiplexed_decimal_tube_scanner.sv
// An item passes the queue, the multiply stage and the result register in turn.
// Throughput: one item per cycle while the queue has room; the phase/tube update in
// front end sets it; the two-entry queue absorbs result-side stalls until it fills.
// Reset (rst, synchronous): blanking phase, tube 0, start time 0, held code 0,
// on_time 2, queue and result register empty.
`timescale 1ns / 1ps

module multiplexed_decimal_tube_scanner #(
  parameter int NUM_TUBES  = 6,
  parameter int TICK_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [mdts_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  mdts_item_if.sink                      item,
  mdts_result_if.source                  result
);

  logic [mdts_pkg::ON_TIME_W-1:0] on_time;
  logic                 accept;
  logic                 q_full, q_not_empty, q_pop;
  mdts_pkg::scan_item_t entry, q_head;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == mdts_pkg::REG_ON_TIME) ? 32'(on_time) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst)
      on_time <= mdts_pkg::ON_TIME_RESET;
    else if (psel && penable && pwrite && pready && paddr[2] == mdts_pkg::REG_ON_TIME)
      on_time <= pwdata[mdts_pkg::ON_TIME_W-1:0];
  end

  assign item.ready = !q_full;
  assign accept     = item.valid && item.ready;

  mdts_front #(
    .NUM_TUBES  (NUM_TUBES),
    .TICK_WIDTH (TICK_WIDTH)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .display_value (item.display_value),
    .tube_enable   (item.tube_enable),
    .now_tick      (item.now_tick),
    .on_time       (on_time),
    .entry         (entry)
  );

  mdts_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (entry),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  mdts_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (q_not_empty),
    .head        (q_head),
    .pop         (q_pop),
    .res_valid   (result.valid),
    .res_ready   (result.ready),
    .digit_code  (result.digit_code),
    .tube_select (result.tube_select),
    .lit         (result.lit)
  );

endmodule

FILE: hw/rtl/mdts_checker.sv
// Port-level checks for the tube scanner, attached to the top level by bind.
// Depends on mdts_pkg for widths.
`timescale 1ns / 1ps

module mdts_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          res_valid,
  input logic                          res_ready,
  input logic [mdts_pkg::CODE_W-1:0]   digit_code,
  input logic [mdts_pkg::SELECT_W-1:0] tube_select,
  input logic                          lit
);

  // at most one anode is driven
  a_select_onehot: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> $onehot0(tube_select))
    else $error("tube_select drives more than one tube");

  // a blanking result never drives an anode
  a_blank_dark: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !lit) |-> (tube_select == '0))
    else $error("anode driven while blanking");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid right after reset");

  // a stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=>
      (res_valid && $stable(digit_code) && $stable(tube_select) && $stable(lit)))
    else $error("stalled result changed");

endmodule

bind multiplexed_decimal_tube_scanner mdts_checker u_mdts_checker (
  .clk         (clk),
  .rst         (rst),
  .res_valid   (result.valid),
  .res_ready   (result.ready),
  .digit_code  (result.digit_code),
  .tube_select (result.tube_select),
  .lit         (result.lit)
);
